// ===== hw/rtl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry stream admission package
// Shared constants, result codes, counter indexes and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

   localparam int MAX_STREAMS = 16;
   localparam int SLOT_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
   localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(MAX_STREAMS);

   localparam int ID_W     = 64;
   localparam int KEY_W    = 2 * ID_W;
   localparam int SEQ_W    = 32;
   localparam int CTR_W    = 64;
   localparam int CIDX_W   = 4;
   localparam int NUM_CTRS = 2 ** CIDX_W;

   // Verdict codes.
   localparam logic [1:0] V_ACCEPTED = 2'd0;
   localparam logic [1:0] V_SKIPPED  = 2'd1;
   localparam logic [1:0] V_REFUSED  = 2'd2;

   // Reason codes.
   localparam logic [2:0] R_NONE      = 3'd0;
   localparam logic [2:0] R_MALFORMED = 3'd1;
   localparam logic [2:0] R_FULL      = 3'd2;
   localparam logic [2:0] R_UNKNOWN   = 3'd3;
   localparam logic [2:0] R_STALE     = 3'd4;
   localparam logic [2:0] R_AHEAD     = 3'd5;

   // Sequence classes.
   localparam logic [2:0] C_NONE    = 3'd0;
   localparam logic [2:0] C_FIRST   = 3'd1;
   localparam logic [2:0] C_NEXT    = 3'd2;
   localparam logic [2:0] C_GAP     = 3'd3;
   localparam logic [2:0] C_DUP     = 3'd4;
   localparam logic [2:0] C_REORDER = 3'd5;

   // Counter indexes, as seen by a counter read.
   localparam logic [CIDX_W-1:0] CI_ACCEPTED  = 4'd0;
   localparam logic [CIDX_W-1:0] CI_SKIPPED   = 4'd1;
   localparam logic [CIDX_W-1:0] CI_REFUSED   = 4'd2;
   localparam logic [CIDX_W-1:0] CI_MALFORMED = 4'd3;
   localparam logic [CIDX_W-1:0] CI_UNKNOWN   = 4'd4;
   localparam logic [CIDX_W-1:0] CI_STALE     = 4'd5;
   localparam logic [CIDX_W-1:0] CI_AHEAD     = 4'd6;
   localparam logic [CIDX_W-1:0] CI_FULL      = 4'd7;
   localparam logic [CIDX_W-1:0] CI_LOST      = 4'd8;
   localparam logic [CIDX_W-1:0] CI_STREAMS   = 4'd9;
   localparam logic [CIDX_W-1:0] CI_MISSING   = 4'd10;
   localparam logic [CIDX_W-1:0] CI_REORDER   = 4'd11;
   localparam logic [CIDX_W-1:0] CI_DUP       = 4'd12;

   typedef struct packed {
      logic              cmd;
      logic              well_formed;
      logic [ID_W-1:0]   source;
      logic [ID_W-1:0]   session;
      logic [SEQ_W-1:0]  seq;
      logic [31:0]       lost;
      logic [31:0]       generation;
      logic              is_sample;
      logic              required;
      logic              signal_known;
      logic [CIDX_W-1:0] counter_index;
   } req_type;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [2:0]       reason;
      logic [2:0]       seq_class;
      logic [CTR_W-1:0] counter_value;
   } rsp_type;

   // Control from the sequencer to the counter bank.
   typedef struct packed {
      logic [CIDX_W-1:0] rd_addr;
      logic              add_en;
      logic [CIDX_W-1:0] add_addr;
      logic [CTR_W-1:0]  addend;
   } ctr_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tsa_ctr_bank.sv =====
// ----------------------------------------------------------------------------
// Counter bank
// Event counters and totals in a RAM, updated by one shared 64-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ctr_bank (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsa_pkg::ctr_ctl_type ctl,
   output logic [tsa_pkg::CTR_W-1:0] rd_value
);

   import tsa_pkg::*;

   logic [NUM_CTRS-1:0] valid_ff;
   logic [NUM_CTRS-1:0] valid_in;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [CTR_W-1:0]    ram_rdata;
   logic [CTR_W-1:0]    sum;

   // A counter never written reads as zero.
   assign rd_value = rd_valid_ff ? ram_rdata : '0;
   assign sum      = rd_value + ctl.addend;

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = valid_ff[ctl.rd_addr];
      if (ctl.add_en) begin
         valid_in[ctl.add_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   tsa_ram #(
      .WIDTH (CTR_W),
      .DEPTH (NUM_CTRS)
   ) u_ctr_ram (
      .clock   (clock),
      .wr_en   (ctl.add_en),
      .wr_addr (ctl.add_addr),
      .wr_data (sum),
      .rd_addr (ctl.rd_addr),
      .rd_data (ram_rdata)
   );

   // An add always follows a read of the same counter.
   a_add_after_read : assert property (@(posedge clock) disable iff (reset)
      ctl.add_en |-> ctl.add_addr == $past(ctl.rd_addr))
      else $error("counter add without a read of the same counter");

endmodule

`default_nettype wire

// ===== hw/rtl/telemetry_stream_admission.sv =====
// ----------------------------------------------------------------------------
// Telemetry stream admission
// Looks up each envelope in a growing stream table, classifies its sequence
// number against the stream watermark and keeps event counters.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                         Moves
//   request   req_valid/req_ready/req_data  one envelope or counter read
//   response  rsp_valid/rsp_ready/rsp_data  one verdict or counter value
//   config    csr_valid/csr_ready/csr_data  live generation, always ready
//
// A counter read passes a read and a wait state to the result register.
// An envelope scans up to N entries, N being the number of streams in the
// table: the table RAM is scanned one entry a cycle, then each counter
// update takes a read and a write step on the shared adder. A malformed
// envelope skips the scan. Reset clears the control state and the counts.
// A finished word waits in the result register; the next word is taken
// while it waits, and a second result waits until the first is taken.
`default_nettype none

module telemetry_stream_admission (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tsa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tsa_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_data
);

   import tsa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_LOOKUP   = 8'b0000_0010,
      S_CLASSIFY = 8'b0000_0100,
      S_UPD_RD   = 8'b0000_1000,
      S_UPD_WR   = 8'b0001_0000,
      S_CNT_RD   = 8'b0010_0000,
      S_CNT_WAIT = 8'b0100_0000,
      S_DONE     = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   req_type             item_ff, item_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         live_gen_ff, live_gen_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [SLOT_W-1:0]   cmp_slot_ff, cmp_slot_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                found_ff, found_in;
   logic [SEQ_W-1:0]    wm_ff, wm_in;
   logic [SEQ_W-1:0]    miss_ff, miss_in;
   logic [NUM_CTRS-1:0] pend_ff, pend_in;
   logic [CIDX_W-1:0]   upd_idx_ff, upd_idx_in;

   logic [KEY_W-1:0]    key_rdata;
   logic [SEQ_W-1:0]    wm_rdata;
   logic [CTR_W-1:0]    ctr_value;
   logic                key_hit;
   logic                full_now;
   logic [SEQ_W-1:0]    seq_dist;
   logic [CIDX_W-1:0]   upd_pick;
   logic                key_we;
   logic                wm_we;
   logic [SLOT_W-1:0]   new_slot;
   logic [SLOT_W-1:0]   wm_waddr;
   ctr_ctl_type         ctr_ctl;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign seq_dist = item_ff.seq - wm_ff;
   assign full_now = !found_ff && (count_ff == COUNT_FULL);
   assign key_hit  = rd_pend_ff && (key_rdata == {item_ff.source, item_ff.session});
   assign new_slot = count_ff[SLOT_W-1:0];

   // A new stream takes the next free entry and starts its watermark there.
   // An existing stream moves its watermark only when the distance is forward.
   assign key_we   = (state_ff == S_CLASSIFY) && !found_ff && !full_now;
   assign wm_we    = key_we || ((state_ff == S_CLASSIFY) && found_ff &&
                                (seq_dist != '0) && !seq_dist[SEQ_W-1]);
   assign wm_waddr = found_ff ? slot_ff : new_slot;

   always_comb begin
      upd_pick = '0;
      for (int i = NUM_CTRS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            upd_pick = CIDX_W'(i);
         end
      end
   end

   always_comb begin
      ctr_ctl.rd_addr  = (state_ff == S_CNT_RD) ? item_ff.counter_index : upd_pick;
      ctr_ctl.add_en   = (state_ff == S_UPD_WR);
      ctr_ctl.add_addr = upd_idx_ff;
      if (upd_idx_ff == CI_LOST) begin
         ctr_ctl.addend = CTR_W'(item_ff.lost);
      end else if (upd_idx_ff == CI_MISSING) begin
         ctr_ctl.addend = CTR_W'(miss_ff);
      end else begin
         ctr_ctl.addend = CTR_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      live_gen_in  = csr_valid ? csr_data : live_gen_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      rd_pend_in   = rd_pend_ff;
      cmp_slot_in  = cmp_slot_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      wm_in        = wm_ff;
      miss_in      = miss_ff;
      pend_in      = pend_ff;
      upd_idx_in   = upd_idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in     = req_data;
               res_in      = '0;
               pend_in     = '0;
               scan_idx_in = '0;
               rd_pend_in  = 1'b0;
               if (req_data.cmd) begin
                  state_in = S_CNT_RD;
               end else if (!req_data.well_formed) begin
                  res_in.verdict        = V_REFUSED;
                  res_in.reason         = R_MALFORMED;
                  pend_in[CI_MALFORMED] = 1'b1;
                  pend_in[CI_REFUSED]   = 1'b1;
                  state_in              = S_UPD_RD;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            // One table read is issued per cycle; its data is compared in the cycle after.
            if (key_hit) begin
               found_in = 1'b1;
               slot_in  = cmp_slot_ff;
               wm_in    = wm_rdata;
               state_in = S_CLASSIFY;
            end else if (scan_idx_ff == count_ff) begin
               found_in = 1'b0;
               state_in = S_CLASSIFY;
            end else begin
               rd_pend_in  = 1'b1;
               cmp_slot_in = scan_idx_ff[SLOT_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_CLASSIFY: begin
            state_in = S_UPD_RD;
            if (full_now) begin
               res_in.verdict      = V_REFUSED;
               res_in.reason       = R_FULL;
               pend_in[CI_FULL]    = 1'b1;
               pend_in[CI_REFUSED] = 1'b1;
            end else begin
               pend_in[CI_LOST] = 1'b1;
               if (!found_ff) begin
                  res_in.seq_class = C_FIRST;
                  count_in         = count_ff + 1'b1;
               end else if (seq_dist == '0) begin
                  res_in.seq_class = C_DUP;
                  pend_in[CI_DUP]  = 1'b1;
               end else if (!seq_dist[SEQ_W-1]) begin
                  res_in.seq_class    = (seq_dist == SEQ_W'(1)) ? C_NEXT : C_GAP;
                  miss_in             = seq_dist - 1'b1;
                  pend_in[CI_MISSING] = 1'b1;
               end else begin
                  res_in.seq_class    = C_REORDER;
                  pend_in[CI_REORDER] = 1'b1;
               end

               if (item_ff.is_sample && !item_ff.signal_known) begin
                  res_in.reason = R_UNKNOWN;
                  if (item_ff.required) begin
                     res_in.verdict      = V_REFUSED;
                     pend_in[CI_UNKNOWN] = 1'b1;
                     pend_in[CI_REFUSED] = 1'b1;
                  end else begin
                     res_in.verdict      = V_SKIPPED;
                     pend_in[CI_SKIPPED] = 1'b1;
                  end
               end else if ((item_ff.generation != '0) &&
                            (item_ff.generation < live_gen_ff)) begin
                  res_in.verdict      = V_REFUSED;
                  res_in.reason       = R_STALE;
                  pend_in[CI_STALE]   = 1'b1;
                  pend_in[CI_REFUSED] = 1'b1;
               end else if ((item_ff.generation != '0) &&
                            (item_ff.generation > live_gen_ff)) begin
                  res_in.verdict      = V_REFUSED;
                  res_in.reason       = R_AHEAD;
                  pend_in[CI_AHEAD]   = 1'b1;
                  pend_in[CI_REFUSED] = 1'b1;
               end else begin
                  res_in.verdict       = V_ACCEPTED;
                  pend_in[CI_ACCEPTED] = 1'b1;
               end
            end
         end
         S_UPD_RD: begin
            if (pend_ff == '0) begin
               state_in = S_DONE;
            end else begin
               upd_idx_in = upd_pick;
               state_in   = S_UPD_WR;
            end
         end
         S_UPD_WR: begin
            pend_in[upd_idx_ff] = 1'b0;
            state_in            = S_UPD_RD;
         end
         S_CNT_RD: begin
            state_in = S_CNT_WAIT;
         end
         S_CNT_WAIT: begin
            if (item_ff.counter_index == CI_STREAMS) begin
               res_in.counter_value = CTR_W'(count_ff);
            end else begin
               res_in.counter_value = ctr_value;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         live_gen_ff  <= '0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         pend_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         live_gen_ff  <= live_gen_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      scan_idx_ff <= scan_idx_in;
      cmp_slot_ff <= cmp_slot_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      wm_ff       <= wm_in;
      miss_ff     <= miss_in;
      upd_idx_ff  <= upd_idx_in;
   end

   tsa_ram #(
      .WIDTH (KEY_W),
      .DEPTH (MAX_STREAMS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (new_slot),
      .wr_data ({item_ff.source, item_ff.session}),
      .rd_addr (scan_idx_ff[SLOT_W-1:0]),
      .rd_data (key_rdata)
   );

   tsa_ram #(
      .WIDTH (SEQ_W),
      .DEPTH (MAX_STREAMS)
   ) u_wm_ram (
      .clock   (clock),
      .wr_en   (wm_we),
      .wr_addr (wm_waddr),
      .wr_data (item_ff.seq),
      .rd_addr (scan_idx_ff[SLOT_W-1:0]),
      .rd_data (wm_rdata)
   );

   tsa_ctr_bank u_ctr_bank (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctr_ctl),
      .rd_value (ctr_value)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("stream count beyond table size");

   a_scan_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |-> scan_idx_ff <= count_ff)
      else $error("table scan ran past the last stream");

   a_new_stream : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLASSIFY && !found_ff && !full_now)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("new stream did not take a table entry");

   a_update_pending : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD_WR) |-> pend_ff[upd_idx_ff])
      else $error("counter update without a pending request");

   a_result_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result shown outside the done step");

endmodule

`default_nettype wire
